/* rtl/rmm_pkg.sv */
// Shared types, constants and the marker dictionary for the redirect marker matcher.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package rmm_pkg;

  localparam int MARKER_COUNT = 12;
  localparam int MARKER_MAX   = 21;
  localparam int COUNT_W      = 10;
  localparam int INDEX_W      = 4;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    VERDICT_FOUND  = 2'd0,
    VERDICT_NONE   = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  localparam int MARKER_LEN [MARKER_COUNT] = '{
    10, 13, 9, 13, 17, 21, 15, 13, 15, 13, 13, 13
  };

  // Marker characters, first character at index 0, zero padded.
  localparam byte_t MARKER_TEXT [MARKER_COUNT][MARKER_MAX] = '{
    '{8'h72, 8'h6b, 8'h6e, 8'h2e, 8'h67, 8'h6f, 8'h76, 8'h2e, 8'h72, 8'h75, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h61, 8'h72, 8'h6e, 8'h69, 8'h6e, 8'h67, 8'h2e, 8'h72, 8'h74, 8'h2e,
      8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6e, 8'h74, 8'h2e, 8'h72, 8'h74, 8'h6b, 8'h2e, 8'h72, 8'h75, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h65, 8'h64, 8'h2e, 8'h72, 8'h74, 8'h2e,
      8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h65, 8'h64, 8'h2e, 8'h72, 8'h75, 8'h76,
      8'h64, 8'h73, 8'h2e, 8'h63, 8'h6f, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h65, 8'h64, 8'h2e, 8'h74, 8'h61, 8'h74,
      8'h74, 8'h65, 8'h6c, 8'h65, 8'h63, 8'h6f, 8'h6d, 8'h2e, 8'h72, 8'h75},
    '{8'h62, 8'h6c, 8'h6f, 8'h63, 8'h6b, 8'h65, 8'h64, 8'h2e, 8'h79, 8'h6f, 8'h74,
      8'h61, 8'h2e, 8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7a, 8'h61, 8'h70, 8'h72, 8'h65, 8'h74, 8'h2e, 8'h67, 8'h6f, 8'h76, 8'h2e,
      8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h61, 8'h69, 8'h73, 8'h2e, 8'h72, 8'h6b, 8'h6e, 8'h2e, 8'h67, 8'h6f,
      8'h76, 8'h2e, 8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h38, 8'h35, 8'h2e, 8'h37, 8'h36, 8'h2e, 8'h31, 8'h38, 8'h30, 8'h2e,
      8'h37, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h38, 8'h35, 8'h2e, 8'h37, 8'h36, 8'h2e, 8'h31, 8'h38, 8'h30, 8'h2e,
      8'h37, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h31, 8'h38, 8'h35, 8'h2e, 8'h37, 8'h36, 8'h2e, 8'h31, 8'h38, 8'h30, 8'h2e,
      8'h37, 8'h37, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

endpackage

`default_nettype wire

/* rtl/rmm_cell.sv */
// One window cell: holds a byte and hands it to its older neighbor on each shift.
// Depends on rmm_pkg.
`default_nettype none

module rmm_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rmm_pkg::cell_ctrl_t  ctrl,
  input  wire rmm_pkg::byte_t       din,
  output rmm_pkg::byte_t            q,
  output rmm_pkg::byte_t            q_next
);

  // Value after this cycle's shift, before any end-of-string clear.
  assign q_next = ctrl.shift ? din : q;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rmm_match.sv */
// Parallel comparators of the window tail against every dictionary marker.
// Depends on rmm_pkg.
`default_nettype none

module rmm_match (
  input  wire rmm_pkg::byte_t                  win [rmm_pkg::MARKER_MAX],
  output logic [rmm_pkg::MARKER_COUNT-1:0]     hits
);

  // win[0] is the newest byte, so a marker ends at win[0].
  for (genvar i = 0; i < rmm_pkg::MARKER_COUNT; i++) begin : g_marker
    localparam int Len = rmm_pkg::MARKER_LEN[i];
    logic [rmm_pkg::MARKER_MAX-1:0] eq;
    for (genvar j = 0; j < rmm_pkg::MARKER_MAX; j++) begin : g_pos
      if (j < Len) begin : g_cmp
        assign eq[j] = (win[Len-1-j] == rmm_pkg::MARKER_TEXT[i][j]);
      end else begin : g_pad
        assign eq[j] = 1'b1;
      end
    end
    assign hits[i] = &eq;
  end

endmodule

`default_nettype wire

/* rtl/redirect_marker_matcher_core.sv */
// The result word is registered and appears on m_tdata in the cycle after the accepted end word.
// Throughput: one word per cycle while s_tready is high; compare logic sits on the shifted window.
// Ready stalls only while a result word waits and m_tready is low.
// Reset (rst, synchronous) clears the window, seen flags, counters, output valid.
// Depends on rmm_pkg, rmm_cell and rmm_match.
`default_nettype none

module redirect_marker_matcher_core #(
  parameter int MAX_LENGTH   = 512,
  parameter int WINDOW_BYTES = 21
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  input  wire logic       s_tuser,   // [0] has_byte
  input  wire logic       s_tlast,   // end_of_text
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // [1:0] verdict, [5:2] marker_index, [7:6] zero
);

  logic in_fire;
  logic take;
  logic done;
  rmm_pkg::cell_ctrl_t ctrl;
  rmm_pkg::byte_t      folded;
  rmm_pkg::byte_t      cell_in   [WINDOW_BYTES];
  rmm_pkg::byte_t      cell_q    [WINDOW_BYTES];
  rmm_pkg::byte_t      cell_next [WINDOW_BYTES];
  rmm_pkg::byte_t      tail      [rmm_pkg::MARKER_MAX];
  logic [rmm_pkg::MARKER_COUNT-1:0] hits;
  logic [rmm_pkg::MARKER_COUNT-1:0] seen;
  logic [rmm_pkg::MARKER_COUNT-1:0] seen_next;
  logic [rmm_pkg::COUNT_W-1:0]      count;
  logic [rmm_pkg::COUNT_W-1:0]      count_next;
  logic                             too_long;
  logic                             too_long_next;
  logic                             found;
  logic [rmm_pkg::INDEX_W-1:0]      index;
  rmm_pkg::verdict_t                verdict;
  logic [rmm_pkg::INDEX_W-1:0]      index_out;

  // Take a new word whenever the output register is free or is being drained.
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign take     = in_fire && s_tuser;
  assign done     = in_fire && s_tlast;

  assign ctrl.shift = take;
  assign ctrl.clear = done;

  // Fold ASCII upper case to lower case; pass every other byte.
  always_comb begin
    if (s_tdata >= 8'h41 && s_tdata <= 8'h5a) begin
      folded = s_tdata + 8'h20;
    end else begin
      folded = s_tdata;
    end
  end

  // Row of cells: cell 0 takes the folded byte, each later cell its neighbor's byte.
  for (genvar k = 0; k < WINDOW_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = folded;
    end else begin : g_link
      assign cell_in[k] = cell_q[k-1];
    end
    rmm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .din    (cell_in[k]),
      .q      (cell_q[k]),
      .q_next (cell_next[k])
    );
  end

  // Compare the window as it stands after this word's shift.
  for (genvar k = 0; k < rmm_pkg::MARKER_MAX; k++) begin : g_tail
    assign tail[k] = cell_next[k];
  end

  rmm_match u_match (
    .win  (tail),
    .hits (hits)
  );

  // Seen flags, length count and overlength flag as they stand after this word.
  always_comb begin
    seen_next     = seen;
    count_next    = count;
    too_long_next = too_long;
    if (take) begin
      seen_next = seen | hits;
      if (count >= rmm_pkg::COUNT_W'(MAX_LENGTH)) begin
        too_long_next = 1'b1;
      end
      if (count != rmm_pkg::COUNT_LIMIT) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      seen     <= '0;
      count    <= '0;
      too_long <= 1'b0;
    end else begin
      seen     <= seen_next;
      count    <= count_next;
      too_long <= too_long_next;
    end
  end

  // Lowest-numbered seen marker wins.
  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = rmm_pkg::MARKER_COUNT - 1; i >= 0; i--) begin
      if (seen_next[i]) begin
        found = 1'b1;
        index = rmm_pkg::INDEX_W'(i);
      end
    end
  end

  // Reject empty or overlong text before looking at any marker.
  always_comb begin
    if (count_next == '0 || too_long_next) begin
      verdict   = rmm_pkg::VERDICT_REJECT;
      index_out = '0;
    end else if (found) begin
      verdict   = rmm_pkg::VERDICT_FOUND;
      index_out = index;
    end else begin
      verdict   = rmm_pkg::VERDICT_NONE;
      index_out = '0;
    end
  end

  // Output register: load on the end word, drop valid once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {2'b00, index_out, verdict};
    end
  end

endmodule

`default_nettype wire

/* rtl/rmm_checker.sv */
// Port-level checks for redirect_marker_matcher_core, bound to the top level.
// Depends on rmm_pkg and redirect_marker_matcher_core.
`default_nettype none

module rmm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("end word gave no result");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != rmm_pkg::VERDICT_FOUND |-> m_tdata[5:2] == 4'd0)
    else $error("marker index set without a match");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[7:6] == 2'd0 &&
      (m_tdata[1:0] != rmm_pkg::VERDICT_FOUND || m_tdata[5:2] < 4'd12))
    else $error("result word out of range");

endmodule

bind redirect_marker_matcher_core rmm_checker u_rmm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/tb_redirect_marker_matcher_core.sv */
// Self-checking testbench for redirect_marker_matcher_core: text words in, one verdict word out
// per string, checked against a behavioral model of the marker search kept in a scoreboard.
// Depends on rmm_pkg (types, dictionary) and the RTL of the core; reads no files.
`default_nettype none

localparam int TEXT_WINDOW = 21;
localparam int MAX_TEXT    = 512;

typedef struct packed {
  rmm_pkg::verdict_t           verdict;
  logic [rmm_pkg::INDEX_W-1:0] index;
} verdict_word_t;

// Tracks the text seen so far and queues the verdict each end word must produce.
class marker_verdict_board;
  rmm_pkg::byte_t                   window [TEXT_WINDOW];  // index 0 newest, already folded
  logic [rmm_pkg::MARKER_COUNT-1:0] seen;
  logic [rmm_pkg::COUNT_W-1:0]      byte_count;
  int                               fill;
  bit                               overlong;
  verdict_word_t                    pending [$];
  int                               results_checked;
  int                               mismatches;

  function new();
    results_checked = 0;
    mismatches      = 0;
    clear_text();
  endfunction

  function void clear_text();
    foreach (window[i]) window[i] = '0;
    seen       = '0;
    byte_count = '0;
    fill       = 0;
    overlong   = 1'b0;
  endfunction

  // Fold, shift and match one accepted word; queue a verdict on the end word.
  function void note_word(rmm_pkg::byte_t text_byte, bit has_byte, bit end_of_text);
    verdict_word_t  outcome;
    rmm_pkg::byte_t folded;
    bit             hit;
    int             len;
    if (has_byte) begin
      folded = (text_byte >= "A" && text_byte <= "Z") ? text_byte + 8'd32 : text_byte;
      for (int i = TEXT_WINDOW - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = folded;
      if (fill < TEXT_WINDOW) fill++;
      if (byte_count >= MAX_TEXT) overlong = 1'b1;
      if (byte_count != rmm_pkg::COUNT_LIMIT) byte_count++;
      for (int m = 0; m < rmm_pkg::MARKER_COUNT; m++) begin
        len = rmm_pkg::MARKER_LEN[m];
        hit = (len <= fill);
        for (int j = 0; j < len; j++)
          if (window[len-1-j] != rmm_pkg::MARKER_TEXT[m][j]) hit = 1'b0;
        if (hit) seen[m] = 1'b1;
      end
    end
    if (!end_of_text) return;
    outcome.verdict = rmm_pkg::VERDICT_NONE;
    outcome.index   = '0;
    if (byte_count == 0 || overlong) begin
      outcome.verdict = rmm_pkg::VERDICT_REJECT;
    end else begin
      // scan downward so the lowest-numbered marker wins
      for (int m = rmm_pkg::MARKER_COUNT - 1; m >= 0; m--) begin
        if (seen[m]) begin
          outcome.verdict = rmm_pkg::VERDICT_FOUND;
          outcome.index   = rmm_pkg::INDEX_W'(m);
        end
      end
    end
    pending.push_back(outcome);
    clear_text();
  endfunction

  task report_mismatch(string msg);
    $display("result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  task check_result(logic [7:0] word);
    verdict_word_t want;
    results_checked++;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %02h", word));
      return;
    end
    want = pending.pop_front();
    if (word[1:0] !== want.verdict)
      report_mismatch($sformatf("verdict %0d, expected %0d", word[1:0], want.verdict));
    if (word[5:2] !== want.index)
      report_mismatch($sformatf("marker_index %0d, expected %0d", word[5:2], want.index));
    if (word[7:6] !== 2'b00)
      report_mismatch($sformatf("pad bits %b, expected 00", word[7:6]));
  endtask
endclass

module tb_redirect_marker_matcher_core;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TOTAL_WORDS = 1450;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;   // [7:0] text_byte
  logic       s_tuser  = 1'b0; // [0] has_byte
  logic       s_tlast  = 1'b0; // end_of_text
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;         // [1:0] verdict, [5:2] marker_index, [7:6] zero

  int             cycles     = 0;
  int             idle_pct   = 8;
  int             stall_pct  = 8;
  int             words_sent = 0;
  rmm_pkg::byte_t text_buf [$];

  marker_verdict_board board;

  always #5 clk = ~clk;

  redirect_marker_matcher_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Result side: check on each handshake, then pick the next ready at random.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** redirect_marker_matcher_core: FAILED **");
      $finish;
    end
  end

  // Drive one word and hold it until accepted; valid stays high into the next word.
  task automatic send_word(input rmm_pkg::byte_t text_byte, input bit has_byte,
                           input bit end_of_text);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= text_byte;
    s_tuser  <= has_byte;
    s_tlast  <= end_of_text;
    do @(posedge clk); while (!s_tready);
    board.note_word(text_byte, has_byte, end_of_text);
    if (has_byte || end_of_text) words_sent++;
  endtask

  // Send text_buf as one string, with stray empty words mixed in; end either on the
  // last byte or on a separate word without a byte.
  task automatic send_text(input bit split_end);
    foreach (text_buf[i]) begin
      if ($urandom_range(19) == 0) send_word(rmm_pkg::byte_t'($urandom), 1'b0, 1'b0);
      send_word(text_buf[i], 1'b1, !split_end && i == text_buf.size() - 1);
    end
    if (split_end || text_buf.size() == 0)
      send_word(rmm_pkg::byte_t'($urandom), 1'b0, 1'b1);
  endtask

  // Build a random string from whole markers, damaged markers and filler.
  function automatic void compose_text();
    int             pieces, mode, m, len, cut, spot;
    rmm_pkg::byte_t c;
    text_buf.delete();
    pieces = ($urandom_range(24) == 0) ? 0 : $urandom_range(1, 4);
    repeat (pieces) begin
      mode = $urandom_range(9);
      if (mode < 6) begin
        m    = $urandom_range(rmm_pkg::MARKER_COUNT - 1);
        len  = rmm_pkg::MARKER_LEN[m];
        cut  = (mode == 4) ? $urandom_range(1, len - 1) : len;
        spot = (mode == 5) ? $urandom_range(len - 1) : -1;
        for (int j = 0; j < cut; j++) begin
          c = rmm_pkg::MARKER_TEXT[m][j];
          if (j == spot) c = rmm_pkg::byte_t'($urandom);
          else if (c >= "a" && c <= "z" && $urandom_range(2) == 0) c = c - 8'd32;
          else if ($urandom_range(149) == 0) c = c | 8'h80;
          text_buf.push_back(c);
        end
      end else begin
        repeat ($urandom_range(8)) begin
          case ($urandom_range(3))
            0: c = rmm_pkg::byte_t'($urandom);
            1: c = rmm_pkg::byte_t'("a" + $urandom_range(25));
            2: c = rmm_pkg::byte_t'("A" + $urandom_range(25));
            default: c = ($urandom_range(10) == 10) ? "." :
                         rmm_pkg::byte_t'("0" + $urandom_range(9));
          endcase
          text_buf.push_back(c);
        end
      end
    end
  endfunction

  initial begin
    int             base, m, len;
    int             lengths [2];
    rmm_pkg::byte_t c;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty string, then an ignored word ahead of another empty string.
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // Byte extremes with no marker, closed by an end word without a byte.
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h3C, 1'b0, 1'b1);
    // Shortest marker in upper case, end flag on its last byte.
    len = rmm_pkg::MARKER_LEN[2];
    for (int j = 0; j < len; j++) begin
      c = rmm_pkg::MARKER_TEXT[2][j];
      if (c >= "a" && c <= "z") c = c - 8'd32;
      send_word(c, 1'b1, j == len - 1);
    end

    // Length limit: exactly at it and one past it.
    // Each string ends in a marker so only the length decides the verdict.
    lengths = '{MAX_TEXT, MAX_TEXT + 1};
    foreach (lengths[n]) begin
      m   = $urandom_range(rmm_pkg::MARKER_COUNT - 1);
      len = rmm_pkg::MARKER_LEN[m];
      text_buf.delete();
      while (text_buf.size() < lengths[n] - len)
        text_buf.push_back(rmm_pkg::byte_t'($urandom_range(128, 255)));
      for (int j = 0; j < len; j++) text_buf.push_back(rmm_pkg::MARKER_TEXT[m][j]);
      send_text(n == 1);
    end

    // Random strings; a stretch in the middle runs with no idling on either side.
    base = words_sent;
    while (words_sent < TOTAL_WORDS) begin
      idle_pct  = (words_sent - base >= 100 && words_sent - base < 300) ? 0 : 8;
      stall_pct = idle_pct;
      compose_text();
      send_text($urandom_range(3) == 0);
    end
    s_tvalid <= 1'b0;

    // Drain outstanding verdicts, then give any spurious result word time to show.
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0)
      $display("** redirect_marker_matcher_core: PASSED **");
    else
      $display("** redirect_marker_matcher_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/rmm_pkg.sv
rtl/rmm_cell.sv
rtl/rmm_match.sv
rtl/redirect_marker_matcher_core.sv
rtl/rmm_checker.sv
bench/tb_redirect_marker_matcher_core.sv
